/* design/ddo_pkg.sv */
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants for the odometry integrator
// Holds the sequencer states, the multiply-accumulate control word, the
// arithmetic constants, the CORDIC angle table and the saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ANGLE_BITS        = 32;

  localparam int ACC_W = 72;   // accumulator width
  localparam int MA_W  = 33;   // multiplier operand A width
  localparam int MB_W  = 26;   // multiplier operand B width
  localparam int CW    = 34;   // CORDIC datapath width

  localparam logic signed [MB_W-1:0] HEADING_SCALE = 26'sd11199533;
  localparam logic signed [MB_W-1:0] TIME_SCALE    = 26'sd1099512;
  localparam logic signed [CW-1:0]   CORDIC_GAIN   = 34'sd652032874;

  localparam logic [15:0] RADIUS_RST       = 16'd3932;
  localparam logic [15:0] INV_BASE_RST     = 16'd11070;
  localparam logic [15:0] SLIP_COEF_RST    = 16'd10912;

  localparam logic [1:0] REG_RADIUS       = 2'd0;
  localparam logic [1:0] REG_INV_BASE     = 2'd1;
  localparam logic [1:0] REG_SLIP_COEF    = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_YAW1, ST_YAW2, ST_FWD, ST_SLIP, ST_YDT, ST_H1, ST_H2, ST_HUPD,
    ST_CORDIC, ST_VX1, ST_VX2, ST_VXDT, ST_XT1, ST_XT2, ST_XUPD,
    ST_VY1, ST_VY2, ST_VYDT, ST_YT1, ST_YT2, ST_YUPD, ST_OUT
  } state_t;

  typedef struct packed {
    logic       en;       // update the accumulator
    logic       accum;    // add to the accumulator instead of loading
    logic       shift;    // scale the product by 2^20
    logic       rnd;      // preload half an LSB at rnd_pos
    logic [5:0] rnd_pos;
  } mac_ctrl_t;

  function automatic logic [31:0] atan_val(input logic [4:0] i);
    case (i)
      5'd0:    atan_val = 32'h20000000;
      5'd1:    atan_val = 32'h12E4051E;
      5'd2:    atan_val = 32'h09FB385B;
      5'd3:    atan_val = 32'h051111D4;
      5'd4:    atan_val = 32'h028B0D43;
      5'd5:    atan_val = 32'h0145D7E1;
      5'd6:    atan_val = 32'h00A2F61E;
      5'd7:    atan_val = 32'h00517C55;
      5'd8:    atan_val = 32'h0028BE53;
      5'd9:    atan_val = 32'h00145F2F;
      5'd10:   atan_val = 32'h000A2F98;
      5'd11:   atan_val = 32'h000517CC;
      5'd12:   atan_val = 32'h00028BE6;
      5'd13:   atan_val = 32'h000145F3;
      5'd14:   atan_val = 32'h0000A2FA;
      5'd15:   atan_val = 32'h0000517D;
      5'd16:   atan_val = 32'h000028BE;
      5'd17:   atan_val = 32'h0000145F;
      5'd18:   atan_val = 32'h00000A30;
      5'd19:   atan_val = 32'h00000518;
      5'd20:   atan_val = 32'h0000028C;
      5'd21:   atan_val = 32'h00000146;
      5'd22:   atan_val = 32'h000000A3;
      5'd23:   atan_val = 32'h00000051;
      5'd24:   atan_val = 32'h00000029;
      5'd25:   atan_val = 32'h00000014;
      5'd26:   atan_val = 32'h0000000A;
      5'd27:   atan_val = 32'h00000005;
      5'd28:   atan_val = 32'h00000003;
      5'd29:   atan_val = 32'h00000001;
      default: atan_val = 32'h00000000;
    endcase
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    if (v > 48'sd8388607) begin
      sat24 = 24'sh7FFFFF;
    end else if (v < -48'sd8388608) begin
      sat24 = 24'sh800000;
    end else begin
      sat24 = v[23:0];
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v > 33'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -33'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

/* design/ddo_mac.sv */
// ----------------------------------------------------------------------------
// ddo_mac: shared multiply-accumulate unit
// One signed multiplier feeding a wide accumulator with optional rounding
// preload and a fixed 2^20 product scale for split wide products.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_mac (
  input  wire logic                                clk,
  input  wire ddo_pkg::mac_ctrl_t                  ctrl,
  input  wire logic signed [ddo_pkg::MA_W-1:0]     a,
  input  wire logic signed [ddo_pkg::MB_W-1:0]     b,
  output logic signed [ddo_pkg::ACC_W-1:0]         acc
);

  localparam int PW = ddo_pkg::MA_W + ddo_pkg::MB_W;

  logic signed [PW-1:0]               prod;
  logic signed [ddo_pkg::ACC_W-1:0]   prod_ext;
  logic signed [ddo_pkg::ACC_W-1:0]   base;
  logic signed [ddo_pkg::ACC_W-1:0]   acc_next;

  assign prod     = a * b;
  assign prod_ext = ddo_pkg::ACC_W'(prod);

  always_comb begin
    if (ctrl.accum) begin
      base = acc;
    end else if (ctrl.rnd) begin
      base = ddo_pkg::ACC_W'(1) << ctrl.rnd_pos;
    end else begin
      base = '0;
    end
    acc_next = base + (ctrl.shift ? (prod_ext <<< 20) : prod_ext);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc <= acc_next;
    end
  end

endmodule

`default_nettype wire

/* design/diff_drive_odometry_integrator_core.sv */
// ----------------------------------------------------------------------------
// diff_drive_odometry_integrator_core: differential-drive odometry integrator
// Turns wheel speeds and tick time into body speeds, heading and position.
// ----------------------------------------------------------------------------
// Each request carries both wheel speeds and the elapsed time. The block forms
// yaw rate, forward speed and slip speed, advances the heading, runs a CORDIC
// for sine and cosine of the new heading and integrates x and y with
// saturation. A request with zero elapsed time produces no result. All
// products go through one shared multiplier one at a time, and the CORDIC runs
// one rotation per cycle. The input is not ready while a request is in work;
// a finished result waits in the output register without blocking the input.
`default_nettype none

module diff_drive_odometry_integrator_core #(
  parameter int CORDIC_ITERATIONS = ddo_pkg::CORDIC_ITERATIONS,
  parameter int ANGLE_BITS        = ddo_pkg::ANGLE_BITS
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_wdata,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // left_wheel_speed[15:0], right_wheel_speed[31:16], elapsed_time[47:32]
  input  wire logic [47:0]  s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // position_x[31:0], position_y[63:32], heading[95:64], forward_speed[119:96],
  // lateral_speed[143:120], yaw_rate[167:144]
  output logic [167:0]      m_tdata
);

  localparam int NITER  = (CORDIC_ITERATIONS < 30) ? CORDIC_ITERATIONS : 30;
  localparam int ITER_W = $clog2(NITER);
  localparam logic [31:0] KEEP = ~((32'(1) << (32 - ANGLE_BITS)) - 32'(1));
  localparam int AW = ddo_pkg::ACC_W;
  localparam int CW = ddo_pkg::CW;

  ddo_pkg::state_t state, state_next;
  ddo_pkg::mac_ctrl_t mac_ctrl;
  logic signed [ddo_pkg::MA_W-1:0] mac_a;
  logic signed [ddo_pkg::MB_W-1:0] mac_b;
  logic signed [AW-1:0] acc;

  logic [15:0] radius, inverse_wheel_base, slip_coefficient;
  logic signed [15:0] left, right;
  logic [15:0] dt;
  logic signed [23:0] yaw, fwd;
  logic signed [24:0] slip;
  logic signed [42:0] part;
  logic signed [31:0] x_acc, y_acc;
  logic [31:0] heading;
  logic signed [CW-1:0] cx, cy, cz;
  logic flip;
  logic [ITER_W-1:0] iter;

  logic [31:0] heading_new, ang_m;
  logic signed [CW-1:0] dx, dy, atan_s, cos_v, sin_v;
  logic signed [ddo_pkg::MB_W-1:0] r_b, dt_b;

  assign s_tready = (state == ddo_pkg::ST_IDLE);
  assign r_b  = ddo_pkg::MB_W'($signed({1'b0, radius}));
  assign dt_b = ddo_pkg::MB_W'($signed({1'b0, dt}));

  assign heading_new = heading + acc[61:30];
  assign ang_m       = heading_new & KEEP;
  assign dx     = cy >>> iter;
  assign dy     = cx >>> iter;
  assign atan_s = CW'($signed({1'b0, ddo_pkg::atan_val(5'(iter))}));
  assign cos_v  = flip ? -cx : cx;
  assign sin_v  = flip ? -cy : cy;

  ddo_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .a    (mac_a),
    .b    (mac_b),
    .acc  (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ddo_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and the operands of the shared multiplier.
  always_comb begin
    state_next = state;
    mac_ctrl   = '0;
    mac_a      = '0;
    mac_b      = '0;
    case (state)
      ddo_pkg::ST_IDLE: begin
        if (s_tvalid && (s_tdata[47:32] != 16'd0)) begin
          state_next = ddo_pkg::ST_YAW1;
        end
      end
      ddo_pkg::ST_YAW1: begin
        mac_ctrl.en = 1'b1;
        mac_a = ddo_pkg::MA_W'(left) - ddo_pkg::MA_W'(right);
        mac_b = r_b;
        state_next = ddo_pkg::ST_YAW2;
      end
      ddo_pkg::ST_YAW2: begin
        mac_ctrl = '{en: 1'b1, accum: 1'b0, shift: 1'b0, rnd: 1'b1, rnd_pos: 6'd19};
        mac_a = ddo_pkg::MA_W'($signed(acc[32:0]));
        mac_b = ddo_pkg::MB_W'($signed({1'b0, inverse_wheel_base}));
        state_next = ddo_pkg::ST_FWD;
      end
      ddo_pkg::ST_FWD: begin
        mac_ctrl = '{en: 1'b1, accum: 1'b0, shift: 1'b0, rnd: 1'b1, rnd_pos: 6'd8};
        mac_a = ddo_pkg::MA_W'(left) + ddo_pkg::MA_W'(right);
        mac_b = r_b;
        state_next = ddo_pkg::ST_SLIP;
      end
      ddo_pkg::ST_SLIP: begin
        mac_ctrl = '{en: 1'b1, accum: 1'b0, shift: 1'b0, rnd: 1'b1, rnd_pos: 6'd15};
        mac_a = ddo_pkg::MA_W'(yaw);
        mac_b = ddo_pkg::MB_W'($signed({1'b0, slip_coefficient}));
        state_next = ddo_pkg::ST_YDT;
      end
      ddo_pkg::ST_YDT: begin
        mac_ctrl.en = 1'b1;
        mac_a = ddo_pkg::MA_W'(yaw);
        mac_b = dt_b;
        state_next = ddo_pkg::ST_H1;
      end
      ddo_pkg::ST_H1, ddo_pkg::ST_XT1, ddo_pkg::ST_YT1: begin
        // Low 20 bits of the split product, with the final rounding preloaded.
        mac_ctrl = '{en: 1'b1, accum: 1'b0, shift: 1'b0, rnd: 1'b1,
                     rnd_pos: (state == ddo_pkg::ST_H1) ? 6'd29 : 6'd39};
        mac_a = ddo_pkg::MA_W'($signed({1'b0, acc[19:0]}));
        mac_b = (state == ddo_pkg::ST_H1) ? ddo_pkg::HEADING_SCALE : ddo_pkg::TIME_SCALE;
        case (state)
          ddo_pkg::ST_H1:  state_next = ddo_pkg::ST_H2;
          ddo_pkg::ST_XT1: state_next = ddo_pkg::ST_XT2;
          default:         state_next = ddo_pkg::ST_YT2;
        endcase
      end
      ddo_pkg::ST_H2, ddo_pkg::ST_XT2, ddo_pkg::ST_YT2: begin
        mac_ctrl = '{en: 1'b1, accum: 1'b1, shift: 1'b1, rnd: 1'b0, rnd_pos: 6'd0};
        mac_a = ddo_pkg::MA_W'($signed(part[42:20]));
        mac_b = (state == ddo_pkg::ST_H2) ? ddo_pkg::HEADING_SCALE : ddo_pkg::TIME_SCALE;
        case (state)
          ddo_pkg::ST_H2:  state_next = ddo_pkg::ST_HUPD;
          ddo_pkg::ST_XT2: state_next = ddo_pkg::ST_XUPD;
          default:         state_next = ddo_pkg::ST_YUPD;
        endcase
      end
      ddo_pkg::ST_HUPD: begin
        state_next = ddo_pkg::ST_CORDIC;
      end
      ddo_pkg::ST_CORDIC: begin
        if (iter == ITER_W'(NITER - 1)) begin
          state_next = ddo_pkg::ST_VX1;
        end
      end
      ddo_pkg::ST_VX1: begin
        mac_ctrl = '{en: 1'b1, accum: 1'b0, shift: 1'b0, rnd: 1'b1, rnd_pos: 6'd29};
        mac_a = ddo_pkg::MA_W'(cos_v);
        mac_b = ddo_pkg::MB_W'(fwd);
        state_next = ddo_pkg::ST_VX2;
      end
      ddo_pkg::ST_VX2: begin
        mac_ctrl = '{en: 1'b1, accum: 1'b1, shift: 1'b0, rnd: 1'b0, rnd_pos: 6'd0};
        mac_a = ddo_pkg::MA_W'(sin_v);
        mac_b = ddo_pkg::MB_W'(slip);
        state_next = ddo_pkg::ST_VXDT;
      end
      ddo_pkg::ST_VY1: begin
        mac_ctrl = '{en: 1'b1, accum: 1'b0, shift: 1'b0, rnd: 1'b1, rnd_pos: 6'd29};
        mac_a = ddo_pkg::MA_W'(sin_v);
        mac_b = ddo_pkg::MB_W'(fwd);
        state_next = ddo_pkg::ST_VY2;
      end
      ddo_pkg::ST_VY2: begin
        mac_ctrl = '{en: 1'b1, accum: 1'b1, shift: 1'b0, rnd: 1'b0, rnd_pos: 6'd0};
        mac_a = -ddo_pkg::MA_W'(cos_v);
        mac_b = ddo_pkg::MB_W'(slip);
        state_next = ddo_pkg::ST_VYDT;
      end
      ddo_pkg::ST_VXDT, ddo_pkg::ST_VYDT: begin
        // The rounded velocity sits in the accumulator above bit 30.
        mac_ctrl.en = 1'b1;
        mac_a = ddo_pkg::MA_W'($signed(acc[55:30]));
        mac_b = dt_b;
        state_next = (state == ddo_pkg::ST_VXDT) ? ddo_pkg::ST_XT1 : ddo_pkg::ST_YT1;
      end
      ddo_pkg::ST_XUPD: begin
        state_next = ddo_pkg::ST_VY1;
      end
      ddo_pkg::ST_YUPD: begin
        state_next = ddo_pkg::ST_OUT;
      end
      ddo_pkg::ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ddo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ddo_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius             <= ddo_pkg::RADIUS_RST;
      inverse_wheel_base <= ddo_pkg::INV_BASE_RST;
      slip_coefficient   <= ddo_pkg::SLIP_COEF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ddo_pkg::REG_RADIUS:       radius             <= cfg_wdata;
        ddo_pkg::REG_INV_BASE:     inverse_wheel_base <= cfg_wdata;
        ddo_pkg::REG_SLIP_COEF:    slip_coefficient   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_acc    <= '0;
      y_acc    <= '0;
      heading  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ddo_pkg::ST_HUPD: heading <= heading_new;
        ddo_pkg::ST_XUPD: x_acc <= ddo_pkg::sat32(33'(x_acc) + 33'($signed(acc[71:40])));
        ddo_pkg::ST_YUPD: y_acc <= ddo_pkg::sat32(33'(y_acc) + 33'($signed(acc[71:40])));
        default: ;
      endcase
      if ((state == ddo_pkg::ST_OUT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers: no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      ddo_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          left  <= s_tdata[15:0];
          right <= s_tdata[31:16];
          dt    <= s_tdata[47:32];
        end
      end
      ddo_pkg::ST_FWD:  yaw <= ddo_pkg::sat24(48'($signed(acc[50:20])));
      ddo_pkg::ST_SLIP: fwd <= ddo_pkg::sat24(48'($signed(acc[42:9])));
      ddo_pkg::ST_YDT:  slip <= acc[40:16];
      ddo_pkg::ST_H1, ddo_pkg::ST_XT1, ddo_pkg::ST_YT1: part <= acc[42:0];
      ddo_pkg::ST_HUPD: begin
        // Fold the angle into the right half plane and flip the result back.
        flip <= ang_m[31] ^ ang_m[30];
        cz   <= CW'($signed({ang_m[30], ang_m[30:0]}));
        cx   <= ddo_pkg::CORDIC_GAIN;
        cy   <= '0;
        iter <= '0;
      end
      ddo_pkg::ST_CORDIC: begin
        if (!cz[CW-1]) begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - atan_s;
        end else begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + atan_s;
        end
        iter <= iter + ITER_W'(1);
      end
      ddo_pkg::ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {yaw, ddo_pkg::sat24(-48'(slip)), fwd, heading, y_acc, x_acc};
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
